@@ rtl/frequency_seven_segment_layout_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef FREQUENCY_SEVEN_SEGMENT_LAYOUT_MACROS_SVH
`define FREQUENCY_SEVEN_SEGMENT_LAYOUT_MACROS_SVH

// Same-cycle implication.
`define FSSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FSSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fssl_pkg.sv @@
`timescale 1ns / 1ps
package fssl_pkg;

    localparam int FREQ_W      = 32;
    localparam int COORD_W     = 8;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int SEG_W       = 7;
    localparam int KIND_W      = 2;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = 10;
    localparam int STEP_BITS   = 8;
    localparam int NUM_STAGES  = 5;
    localparam int PAD_W       = NUM_STAGES * STEP_BITS;
    localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
    localparam int VAL_W       = FREQ_W + 1;
    localparam int MAX_GLYPHS  = 8;
    localparam int GLYPH_IDX_W = 3;
    localparam int GLYPH_CNT_W = 4;
    localparam int STEP_W      = CFG_W + 1;
    localparam int SPAN_W      = 11;
    localparam int SUM_W       = COORD_W + 1;
    localparam int S_TDATA_W   = FREQ_W + 2 * COORD_W;
    localparam int M_FIELDS_W  = SEG_W + 3 * COORD_W;
    localparam int M_TDATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_GAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_GAP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_HEIGHT = 3'd4;

    localparam logic [CFG_W-1:0] RST_DIGIT_WIDTH  = 6'd16;
    localparam logic [CFG_W-1:0] RST_DIGIT_GAP    = 6'd4;
    localparam logic [CFG_W-1:0] RST_DOT_WIDTH    = 6'd3;
    localparam logic [CFG_W-1:0] RST_DOT_GAP      = 6'd2;
    localparam logic [CFG_W-1:0] RST_DIGIT_HEIGHT = 6'd28;

    localparam logic [KIND_W-1:0] KIND_DIGIT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LABEL = 2'd2;

    localparam logic [FREQ_W-1:0] HUNDRED_HZ = 32'd100000;
    localparam logic [FREQ_W-1:0] TEN_HZ     = 32'd10000;
    localparam logic [VAL_W-1:0]  ROUND_WHOLE      = 33'd500;
    localparam logic [VAL_W-1:0]  ROUND_TENTH      = 33'd50;
    localparam logic [VAL_W-1:0]  ROUND_HUNDREDTH  = 33'd5;

    localparam logic [SUM_W-1:0]   LABEL_WIDTH = 9'd16;
    localparam logic [SUM_W-1:0]   LABEL_LIMIT = 9'd128;
    localparam logic [COORD_W-1:0] LABEL_RISE  = 8'd8;
    localparam logic [COORD_W-1:0] WIDTH_MAX   = 8'd255;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_bcd;

    typedef struct packed {
        logic [CFG_W-1:0] digit_width;
        logic [CFG_W-1:0] digit_gap;
        logic [CFG_W-1:0] dot_width;
        logic [CFG_W-1:0] dot_gap;
        logic [CFG_W-1:0] digit_height;
    } t_cfg;

    typedef struct packed {
        t_bcd               digits;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_digits;

    typedef struct packed {
        logic [MAX_GLYPHS-1:0][KIND_W-1:0] kind;
        logic [MAX_GLYPHS-1:0][SEG_W-1:0]  seg;
        logic [GLYPH_CNT_W-1:0]            count;
        logic [COORD_W-1:0]                x;
        logic [COORD_W-1:0]                y;
        logic [COORD_W-1:0]                label_y;
        logic [COORD_W-1:0]                total_width;
        logic [STEP_W-1:0]                 digit_step;
        logic [STEP_W-1:0]                 dot_step;
    } t_layout;

    function automatic logic [SEG_W-1:0] seg7(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0:    code = 7'h3F;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5B;
            4'd3:    code = 7'h4F;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6D;
            4'd6:    code = 7'h7D;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h6F;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

    // Shift-and-add-3 over one chunk of binary bits, msb first.
    function automatic t_bcd dabble_chunk(input t_bcd bcd_in,
                                          input logic [STEP_BITS-1:0] chunk);
        t_bcd             acc;
        logic [BCD_W-1:0] flat;
        acc = bcd_in;
        for (int s = STEP_BITS - 1; s >= 0; s--) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (acc[d] >= 4'd5) begin
                    acc[d] = acc[d] + 4'd3;
                end
            end
            flat = acc;
            flat = {flat[BCD_W-2:0], chunk[s]};
            acc  = flat;
        end
        return acc;
    endfunction

endpackage

@@ rtl/fssl_convert.sv @@
`timescale 1ns / 1ps
module fssl_convert (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [fssl_pkg::FREQ_W-1:0]     i_freq,
    input  logic [fssl_pkg::COORD_W-1:0]    i_x,
    input  logic [fssl_pkg::COORD_W-1:0]    i_y,
    output logic                            o_valid,
    input  logic                            i_ready,
    output fssl_pkg::t_digits               o_data
);

    localparam int LAST = fssl_pkg::NUM_STAGES;
    localparam int PW   = fssl_pkg::PAD_W;
    localparam int SB   = fssl_pkg::STEP_BITS;

    logic [LAST:0]                  r_vld;
    logic [PW-1:0]                  r_bits [0:LAST-1];
    fssl_pkg::t_bcd                 r_bcd  [1:LAST];
    logic [fssl_pkg::COORD_W-1:0]   r_x    [0:LAST];
    logic [fssl_pkg::COORD_W-1:0]   r_y    [0:LAST];

    logic [LAST:0]                  w_load;
    logic [LAST:0]                  w_move;
    logic [fssl_pkg::VAL_W-1:0]     w_round;
    logic [fssl_pkg::VAL_W-1:0]     w_value;

    // rounding offset by range
    always_comb begin
        priority if (i_freq >= fssl_pkg::HUNDRED_HZ) begin
            w_round = fssl_pkg::ROUND_WHOLE;
        end else if (i_freq >= fssl_pkg::TEN_HZ) begin
            w_round = fssl_pkg::ROUND_TENTH;
        end else begin
            w_round = fssl_pkg::ROUND_HUNDREDTH;
        end
        w_value = {1'b0, i_freq} + w_round;
    end

    always_comb begin
        w_move[LAST] = r_vld[LAST] && i_ready;
        w_load[LAST] = !r_vld[LAST] || w_move[LAST];
        for (int j = LAST - 1; j >= 0; j--) begin
            w_move[j] = r_vld[j] && w_load[j + 1];
            w_load[j] = !r_vld[j] || w_move[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_load[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int j = 1; j <= LAST; j++) begin
                if (w_load[j]) begin
                    r_vld[j] <= r_vld[j - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0] && i_valid) begin
            r_bits[0] <= PW'(w_value);
            r_x[0]    <= i_x;
            r_y[0]    <= i_y;
        end
        if (w_move[0]) begin
            r_bcd[1] <= fssl_pkg::dabble_chunk('0, r_bits[0][PW-1 -: SB]);
            r_x[1]   <= r_x[0];
            r_y[1]   <= r_y[0];
            if (LAST > 1) begin
                r_bits[1] <= r_bits[0];
            end
        end
        for (int j = 2; j <= LAST; j++) begin
            if (w_move[j - 1]) begin
                r_bcd[j] <= fssl_pkg::dabble_chunk(r_bcd[j - 1],
                                                   r_bits[j - 1][PW-1-(j-1)*SB -: SB]);
                r_x[j]   <= r_x[j - 1];
                r_y[j]   <= r_y[j - 1];
                if (j < LAST) begin
                    r_bits[j] <= r_bits[j - 1];
                end
            end
        end
    end

    assign o_ready = w_load[0];
    assign o_valid = r_vld[LAST];

    always_comb begin
        o_data.digits = r_bcd[LAST];
        o_data.x      = r_x[LAST];
        o_data.y      = r_y[LAST];
    end

endmodule

@@ rtl/fssl_layout.sv @@
`timescale 1ns / 1ps
module fssl_layout (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fssl_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  fssl_pkg::t_digits   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output fssl_pkg::t_layout   o_data
);

    // decimal positions of the rounded value
    localparam int INT_LSD   = 3;
    localparam int NODOT_LSD = 5;
    localparam int TENS_POS  = 4;
    localparam int FRAC1_POS = 2;
    localparam int FRAC2_POS = 1;

    localparam logic [1:0] FRAC_NONE = 2'd0;
    localparam logic [1:0] FRAC_ONE  = 2'd1;
    localparam logic [1:0] FRAC_TWO  = 2'd2;

    localparam int CW = fssl_pkg::GLYPH_CNT_W;
    localparam int SW = fssl_pkg::SPAN_W;

    logic                                r_vld;
    fssl_pkg::t_layout                   r_data;
    fssl_pkg::t_layout                   n_data;

    logic                                w_load;
    logic [fssl_pkg::GLYPH_IDX_W-1:0]    w_nd;
    logic [CW-1:0]                       w_nd4;
    logic                                w_nodot;
    logic [1:0]                          w_nfrac;
    logic [CW-1:0]                       w_ndig;
    logic [fssl_pkg::STEP_W-1:0]         w_dstep;
    logic [fssl_pkg::STEP_W-1:0]         w_pstep;
    logic [SW-1:0]                       w_span;
    logic [SW-1:0]                       w_total;
    logic [fssl_pkg::COORD_W-1:0]        w_label_x;
    logic                                w_fit;

    always_comb begin
        w_nd = fssl_pkg::GLYPH_IDX_W'(1);
        for (int k = INT_LSD; k < fssl_pkg::NUM_DIGITS; k++) begin
            if (i_data.digits[k] != '0) begin
                w_nd = fssl_pkg::GLYPH_IDX_W'(k - (INT_LSD - 1));
            end
        end
        w_nd4 = {1'b0, w_nd};
        w_nodot = 1'b0;
        for (int k = NODOT_LSD; k < fssl_pkg::NUM_DIGITS; k++) begin
            if (i_data.digits[k] != '0) begin
                w_nodot = 1'b1;
            end
        end
        priority if (w_nodot) begin
            w_nfrac = FRAC_NONE;
        end else if (i_data.digits[TENS_POS] != '0) begin
            w_nfrac = FRAC_ONE;
        end else begin
            w_nfrac = FRAC_TWO;
        end
    end

    always_comb begin : glyph_list
        logic [CW-1:0]                   pos;
        logic [fssl_pkg::DIGIT_W-1:0]    sel;
        n_data = '0;
        for (int p = 0; p < fssl_pkg::MAX_GLYPHS; p++) begin
            pos = CW'(p);
            sel = fssl_pkg::DIGIT_W'(INT_LSD - 1) + w_nd4 - pos;
            priority if (pos < w_nd4) begin
                n_data.kind[p] = fssl_pkg::KIND_DIGIT;
                n_data.seg[p]  = fssl_pkg::seg7(i_data.digits[sel]);
            end else if (w_nfrac != FRAC_NONE && pos == w_nd4) begin
                n_data.kind[p] = fssl_pkg::KIND_DOT;
                n_data.seg[p]  = '0;
            end else if (w_nfrac != FRAC_NONE && pos == w_nd4 + CW'(1)) begin
                n_data.kind[p] = fssl_pkg::KIND_DIGIT;
                n_data.seg[p]  = fssl_pkg::seg7(i_data.digits[FRAC1_POS]);
            end else if (w_nfrac == FRAC_TWO && pos == w_nd4 + CW'(2)) begin
                n_data.kind[p] = fssl_pkg::KIND_DIGIT;
                n_data.seg[p]  = fssl_pkg::seg7(i_data.digits[FRAC2_POS]);
            end else begin
                n_data.kind[p] = fssl_pkg::KIND_LABEL;
                n_data.seg[p]  = '0;
            end
        end

        w_ndig    = w_nd4 + CW'(w_nfrac);
        w_dstep   = {1'b0, i_cfg.digit_width} + {1'b0, i_cfg.digit_gap};
        w_pstep   = {1'b0, i_cfg.dot_width} + {1'b0, i_cfg.dot_gap};
        w_span    = SW'(w_ndig) * SW'(w_dstep)
                  + ((w_nfrac != FRAC_NONE) ? SW'(w_pstep) : '0);
        w_total   = SW'(fssl_pkg::LABEL_WIDTH) + w_span;
        w_label_x = i_data.x + w_span[fssl_pkg::COORD_W-1:0];
        w_fit     = ({1'b0, w_label_x} + fssl_pkg::LABEL_WIDTH) <= fssl_pkg::LABEL_LIMIT;

        n_data.count       = w_ndig + CW'(w_nfrac != FRAC_NONE) + CW'(w_fit);
        n_data.x           = i_data.x;
        n_data.y           = i_data.y;
        n_data.label_y     = i_data.y + {2'b00, i_cfg.digit_height} - fssl_pkg::LABEL_RISE;
        n_data.total_width = (w_total > SW'(fssl_pkg::WIDTH_MAX)) ? fssl_pkg::WIDTH_MAX
                                                                 : w_total[7:0];
        n_data.digit_step  = w_dstep;
        n_data.dot_step    = w_pstep;
    end

    assign w_load = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_ready = w_load;
    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

@@ rtl/fssl_emit.sv @@
`timescale 1ns / 1ps
module fssl_emit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  fssl_pkg::t_layout               i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [fssl_pkg::KIND_W-1:0]     o_kind,
    output logic [fssl_pkg::SEG_W-1:0]      o_seg,
    output logic [fssl_pkg::COORD_W-1:0]    o_x,
    output logic [fssl_pkg::COORD_W-1:0]    o_y,
    output logic [fssl_pkg::COORD_W-1:0]    o_width,
    output logic                            o_last
);

    localparam int XW = fssl_pkg::COORD_W;

    logic                                r_vld;
    fssl_pkg::t_layout                   r_item;
    logic [fssl_pkg::GLYPH_IDX_W-1:0]    r_k;
    logic [XW-1:0]                       r_x;

    logic                                w_take;
    logic                                w_last;
    logic                                w_load;
    logic [fssl_pkg::KIND_W-1:0]         w_kind;

    assign w_kind = r_item.kind[r_k];
    assign w_last = ({1'b0, r_k} + fssl_pkg::GLYPH_CNT_W'(1)) == r_item.count;
    assign w_take = r_vld && i_ready;
    assign w_load = !r_vld || (w_take && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_k   <= '0;
        end else if (w_load) begin
            r_vld <= i_valid;
            r_k   <= '0;
        end else if (w_take) begin
            r_k   <= r_k + fssl_pkg::GLYPH_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_item <= i_data;
            r_x    <= i_data.x;
        end else if (w_take && !w_last) begin
            r_x <= r_x + ((w_kind == fssl_pkg::KIND_DIGIT) ? XW'(r_item.digit_step)
                                                          : XW'(r_item.dot_step));
        end
    end

    assign o_ready = w_load;
    assign o_valid = r_vld;
    assign o_kind  = w_kind;
    assign o_seg   = r_item.seg[r_k];
    assign o_x     = r_x;
    assign o_y     = (w_kind == fssl_pkg::KIND_LABEL) ? r_item.label_y : r_item.y;
    assign o_width = r_item.total_width;
    assign o_last  = w_last;

endmodule

@@ rtl/frequency_seven_segment_layout.sv @@
`timescale 1ns / 1ps
// Channel     Dir  Fields
// s_axis      in   tdata: freq_millihertz[31:0], origin_x[39:32], origin_y[47:40]
// m_axis      out  tdata: segments, glyph_x, glyph_y, total_width; tuser: glyph_kind;
//                  tlast: last
// cfg         in   i_cfg_we, i_cfg_idx, i_cfg_data (6-bit registers 0..4)
//
// A word is accepted every cycle while the stages have room; the first glyph passes
// through an input register, five 8-bit BCD stages, the layout stage and the glyph register.
// Each frequency then holds the output for 3 to 8 glyphs, so the glyph serializer sets
// the sustained rate at one glyph per cycle while m_axis_tready is high.
// Reset (i_rst_n low, synchronous) empties all stages and reloads register defaults.
// m_axis_tready low holds the glyph; seven more words queue before s_axis_tready drops.
module frequency_seven_segment_layout (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // freq_millihertz, origin_x, origin_y
    input  logic [fssl_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // segments, glyph_x, glyph_y, total_width, zero pad
    output logic [fssl_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // glyph_kind
    output logic [fssl_pkg::KIND_W-1:0]         m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [fssl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fssl_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int FW = fssl_pkg::FREQ_W;
    localparam int XW = fssl_pkg::COORD_W;

    fssl_pkg::t_cfg         r_cfg;
    logic                   w_cv_valid;
    logic                   w_cv_ready;
    fssl_pkg::t_digits      w_cv_data;
    logic                   w_ly_valid;
    logic                   w_ly_ready;
    fssl_pkg::t_layout      w_ly_data;
    logic [fssl_pkg::SEG_W-1:0] w_seg;
    logic [XW-1:0]          w_x;
    logic [XW-1:0]          w_y;
    logic [XW-1:0]          w_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.digit_width  <= fssl_pkg::RST_DIGIT_WIDTH;
            r_cfg.digit_gap    <= fssl_pkg::RST_DIGIT_GAP;
            r_cfg.dot_width    <= fssl_pkg::RST_DOT_WIDTH;
            r_cfg.dot_gap      <= fssl_pkg::RST_DOT_GAP;
            r_cfg.digit_height <= fssl_pkg::RST_DIGIT_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fssl_pkg::CFG_DIGIT_WIDTH:  r_cfg.digit_width  <= i_cfg_data;
                fssl_pkg::CFG_DIGIT_GAP:    r_cfg.digit_gap    <= i_cfg_data;
                fssl_pkg::CFG_DOT_WIDTH:    r_cfg.dot_width    <= i_cfg_data;
                fssl_pkg::CFG_DOT_GAP:      r_cfg.dot_gap      <= i_cfg_data;
                fssl_pkg::CFG_DIGIT_HEIGHT: r_cfg.digit_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fssl_convert u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_freq  (s_axis_tdata[FW-1:0]),
        .i_x     (s_axis_tdata[FW+XW-1:FW]),
        .i_y     (s_axis_tdata[FW+2*XW-1:FW+XW]),
        .o_valid (w_cv_valid),
        .i_ready (w_cv_ready),
        .o_data  (w_cv_data)
    );

    fssl_layout u_layout (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_cv_valid),
        .o_ready (w_cv_ready),
        .i_data  (w_cv_data),
        .o_valid (w_ly_valid),
        .i_ready (w_ly_ready),
        .o_data  (w_ly_data)
    );

    fssl_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ly_valid),
        .o_ready (w_ly_ready),
        .i_data  (w_ly_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_seg   (w_seg),
        .o_x     (w_x),
        .o_y     (w_y),
        .o_width (w_width),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(fssl_pkg::M_TDATA_W - fssl_pkg::M_FIELDS_W){1'b0}},
                           w_width, w_y, w_x, w_seg};

endmodule

@@ rtl/fssl_checker.sv @@
`timescale 1ns / 1ps
`include "frequency_seven_segment_layout_macros.svh"
module fssl_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [fssl_pkg::M_TDATA_W-1:0]      i_m_tdata,
    input  logic [fssl_pkg::KIND_W-1:0]         i_m_tuser,
    input  logic                                i_m_tlast
);

    localparam int SW = fssl_pkg::SEG_W;
    localparam int XW = fssl_pkg::COORD_W;

    logic          w_take;
    logic [SW-1:0] w_seg;
    logic [XW-1:0] w_width;

    assign w_take  = i_m_tvalid && i_m_tready;
    assign w_seg   = i_m_tdata[SW-1:0];
    assign w_width = i_m_tdata[SW+3*XW-1:SW+2*XW];

    `FSSL_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast), "glyph word changed while stalled")

    `FSSL_ASSERT_IMPLY(a_label_last, i_clk, i_rst_n, i_m_tvalid && i_m_tuser == fssl_pkg::KIND_LABEL, i_m_tlast, "label glyph not last")

    `FSSL_ASSERT_IMPLY(a_blank_segments, i_clk, i_rst_n, i_m_tvalid && i_m_tuser != fssl_pkg::KIND_DIGIT, w_seg == '0, "segments set on a non-digit glyph")

    `FSSL_ASSERT_NEXT(a_width_frame, i_clk, i_rst_n, w_take && !i_m_tlast, i_m_tvalid && w_width == $past(w_width), "frame broken or width changed inside a frame")

endmodule

bind frequency_seven_segment_layout fssl_checker u_fssl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_m_tlast  (m_axis_tlast)
);
